FILE: rtl/rlcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcd_pkg
// shared types and constants of the column run-length decoder
// ----------------------------------------------------------------------------
package rlcd_pkg;

    localparam logic [7:0] LEN_MASK  = 8'h3F;
    localparam logic [7:0] KIND_MASK = 8'hC0;
    localparam logic [7:0] LIT_BIT   = 8'h40;

    localparam int RUN_MAX        = 64;
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_FIFO_AW    = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;

    typedef enum logic [1:0] {
        KIND_WORD = 2'd0,
        KIND_SKIP = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // one queued command: a word repeated cnt_m1 + 1 times
    typedef struct packed {
        logic [15:0] word;
        t_kind       kind;
        logic        last;
        logic [5:0]  cnt_m1;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/rlcd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcd_in_if
// byte channel of the compressed column stream
// ----------------------------------------------------------------------------
interface rlcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/rlcd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcd_out_if
// decoded word channel
// ----------------------------------------------------------------------------
interface rlcd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] word_value;
    logic [1:0]  result_kind;
    logic        column_end;

    modport source (output valid, output word_value, output result_kind,
                    output column_end, input ready);
    modport sink   (input valid, input word_value, input result_kind,
                    input column_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/rlcd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcd_front
// byte parser: tracks the column phase and queues expansion commands
// ----------------------------------------------------------------------------
module rlcd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_skip_mode,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_space,
    output logic               o_ready,
    output logic               o_push,
    output rlcd_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        PH_COUNT  = 3'd0,
        PH_HEADER = 3'd1,
        PH_LIT_LO = 3'd2,
        PH_LIT_HI = 3'd3,
        PH_REP_LO = 3'd4,
        PH_REP_HI = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_runs, n_runs;
    logic [6:0]  r_words, n_words;
    logic [7:0]  r_low, n_low;

    logic        w_accept;
    logic [7:0]  w_len;
    logic [6:0]  w_words_dec;
    logic        w_run_last;

    assign o_ready     = i_space;
    assign w_accept    = i_valid && i_space;
    assign w_len       = i_byte & rlcd_pkg::LEN_MASK;
    assign w_words_dec = r_words - 7'd1;
    assign w_run_last  = (r_runs == 8'd1);

    always_comb begin
        n_phase = r_phase;
        n_runs  = r_runs;
        n_words = r_words;
        n_low   = r_low;
        o_push  = 1'b0;
        o_cmd   = '{word: 16'd0, kind: rlcd_pkg::KIND_WORD, last: 1'b0, cnt_m1: 6'd0};
        if (w_accept) begin
            unique case (r_phase)
                PH_COUNT: begin
                    n_runs = i_byte;
                    if (i_byte == 8'd0) begin
                        o_push     = 1'b1;
                        o_cmd.kind = rlcd_pkg::KIND_END;
                        o_cmd.last = 1'b1;
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if ((i_byte & rlcd_pkg::KIND_MASK) == 8'd0) begin
                        // zero run goes out whole
                        o_push       = 1'b1;
                        o_cmd.kind   = i_skip_mode ? rlcd_pkg::KIND_SKIP
                                                   : rlcd_pkg::KIND_WORD;
                        o_cmd.last   = w_run_last;
                        o_cmd.cnt_m1 = w_len[5:0];
                        n_runs       = r_runs - 8'd1;
                        n_words      = 7'd0;
                        n_phase      = w_run_last ? PH_COUNT : PH_HEADER;
                    end else begin
                        n_words = w_len[6:0] + 7'd1;
                        n_phase = ((i_byte & rlcd_pkg::LIT_BIT) != 8'd0) ? PH_LIT_LO
                                                                         : PH_REP_LO;
                    end
                end
                PH_LIT_LO: begin
                    n_low   = i_byte;
                    n_phase = PH_LIT_HI;
                end
                PH_LIT_HI: begin
                    o_push     = 1'b1;
                    o_cmd.word = {i_byte, r_low};
                    n_words    = w_words_dec;
                    if (w_words_dec == 7'd0) begin
                        o_cmd.last = w_run_last;
                        n_runs     = r_runs - 8'd1;
                        n_phase    = w_run_last ? PH_COUNT : PH_HEADER;
                    end else begin
                        n_phase = PH_LIT_LO;
                    end
                end
                PH_REP_LO: begin
                    n_low   = i_byte;
                    n_phase = PH_REP_HI;
                end
                PH_REP_HI: begin
                    o_push     = 1'b1;
                    o_cmd.word = {i_byte, r_low};
                    o_cmd.last = w_run_last;
                    if (r_words == 7'd0 || r_words > 7'(rlcd_pkg::RUN_MAX)) begin
                        o_cmd.cnt_m1 = 6'd0;
                    end else begin
                        o_cmd.cnt_m1 = w_words_dec[5:0];
                    end
                    n_runs  = r_runs - 8'd1;
                    n_words = 7'd0;
                    n_phase = w_run_last ? PH_COUNT : PH_HEADER;
                end
                default: begin
                    n_phase = PH_COUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT;
            r_runs  <= 8'd0;
            r_words <= 7'd0;
            r_low   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_runs  <= n_runs;
            r_words <= n_words;
            r_low   <= n_low;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rlcd_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcd_cmd_fifo
// short command queue between parser and expander
// ----------------------------------------------------------------------------
module rlcd_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rlcd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output rlcd_pkg::t_cmd     o_cmd,
    output logic               o_full,
    output logic               o_empty
);

    localparam int AW = rlcd_pkg::CMD_FIFO_AW;
    localparam int CW = $clog2(rlcd_pkg::CMD_FIFO_DEPTH + 1);

    rlcd_pkg::t_cmd r_mem [rlcd_pkg::CMD_FIFO_DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(rlcd_pkg::CMD_FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(rlcd_pkg::CMD_FIFO_DEPTH - 1)) ? '0
                                                                           : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(rlcd_pkg::CMD_FIFO_DEPTH - 1)) ? '0
                                                                           : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rlcd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcd_back
// run expander: while the sink is ready, turns one command into its words, one per cycle
// ----------------------------------------------------------------------------
module rlcd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rlcd_pkg::t_cmd i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [15:0]        o_word,
    output logic [1:0]         o_kind,
    output logic               o_last
);

    rlcd_pkg::t_cmd r_cmd;
    logic           r_busy;
    logic [5:0]     r_left;
    logic           r_out_valid;
    logic [15:0]    r_word;
    logic [1:0]     r_kind;
    logic           r_last;

    logic           w_load;
    logic           w_done;

    assign w_load = !r_out_valid || i_out_ready;
    assign w_done = r_busy && w_load && (r_left == 6'd0);
    assign o_pop  = !i_empty && (!r_busy || w_done);

    assign o_out_valid = r_out_valid;
    assign o_word      = r_word;
    assign o_kind      = r_kind;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_left      <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_left <= i_cmd.cnt_m1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (r_busy && w_load) begin
                r_left <= r_left - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_load && r_busy) begin
            r_word <= r_cmd.word;
            r_kind <= r_cmd.kind;
            r_last <= (r_left == 6'd0) ? r_cmd.last : 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/column_run_length_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_run_length_decoder_core
// decodes a run-length coded column byte stream into 16-bit words
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// i_in      in   valid/ready    stream_byte[7:0]
// o_out     out  valid/ready    word_value[15:0], result_kind[1:0], column_end
// cfg       in   i_cfg_we       i_cfg_wdata (skip_mode)
//
// one byte is taken per cycle while the command queue has room; a literal
// word costs two bytes, the low byte first and then the high byte
// zero and repeat runs expand at one word per cycle in the back end while
// the sink is ready, up to 64 words per run; bytes keep flowing until the queue fills
// an output register parts the back end from the sink, so a stall there
// only holds the expander; the parser stalls once the queue is full
// reset is synchronous and clears phase, counters, queue and skip mode
// ----------------------------------------------------------------------------
module column_run_length_decoder_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_wdata,
    rlcd_in_if.sink     i_in,
    rlcd_out_if.source  o_out
);

    // skip mode register, sampled by the parser on a zero run header
    logic r_skip_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_skip_mode <= i_cfg_wdata;
        end
    end

    // parser to queue
    rlcd_pkg::t_cmd w_push_cmd;
    logic           w_push;
    logic           w_fifo_full;

    // queue to expander
    rlcd_pkg::t_cmd w_pop_cmd;
    logic           w_pop;
    logic           w_fifo_empty;

    rlcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_skip_mode (r_skip_mode),
        .i_valid     (i_in.valid),
        .i_byte      (i_in.stream_byte),
        .i_space     (!w_fifo_full),
        .o_ready     (i_in.ready),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    rlcd_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_full  (w_fifo_full),
        .o_empty (w_fifo_empty)
    );

    rlcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_pop_cmd),
        .i_empty     (w_fifo_empty),
        .o_pop       (w_pop),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_word      (o_out.word_value),
        .o_kind      (o_out.result_kind),
        .o_last      (o_out.column_end)
    );

    // queue never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_full)
        else $error("command queue overflow");

    // queue never read when empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_empty)
        else $error("command queue underflow");

    // an end marker closes its column and carries no word
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind == rlcd_pkg::KIND_END)
            |-> (o_out.column_end && o_out.word_value == 16'd0))
        else $error("malformed end marker");

    // skip results carry a zero word
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind == rlcd_pkg::KIND_SKIP)
            |-> (o_out.word_value == 16'd0))
        else $error("skip result with nonzero word");

endmodule

`default_nettype wire
